// ===== design/bscf_pkg.sv =====
// Shared types and constants for the pressure compensation filter
package bscf_pkg;

  localparam int CalWideW = 48;
  localparam int CalNarW  = 32;
  localparam int CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AC123 = 3'd0,
    REG_AC456 = 3'd1,
    REG_B12   = 3'd2,
    REG_MCMD  = 3'd3,
    REG_OSS   = 3'd4
  } cfg_reg_t;

  // sequencer steps; each multiply runs in the shared multiplier, each divide in the serial divider
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_X1_MUL,
    ST_X1_DONE,
    ST_X2_DIV,
    ST_B5,
    ST_SQ_MUL,
    ST_X1P_MUL,
    ST_X2P_MUL,
    ST_B3,
    ST_X1Q_MUL,
    ST_X2Q_MUL,
    ST_B4_MUL,
    ST_B4_CHK,
    ST_B7_MUL,
    ST_Q_DIV,
    ST_P_SQ,
    ST_P_C1,
    ST_P_C2,
    ST_P_FIN,
    ST_OUT
  } state_t;

  localparam logic signed [31:0] K_T0  = 32'sd4000;
  localparam logic signed [31:0] K_C1  = 32'sd3038;
  localparam logic signed [31:0] K_C2  = -32'sd7357;
  localparam logic signed [31:0] K_C3  = 32'sd3791;
  localparam logic [31:0]        K_PSC = 32'd50000;
  localparam logic [31:0]        K_OFS = 32'd32768;
  localparam logic [31:0]        K_MSB = 32'h8000_0000;

endpackage

// ===== design/baro_sensor_compensation_filter.sv =====
// Top level: sequenced compensation with shared multiplier and serial divider
//
// Usage: the input channel carries one raw temperature and one raw pressure
// word per item (in_valid / in_stall). An item is taken only when the block
// is idle; in_stall is high while an item is worked on or its result waits.
// Each item runs through a small sequencer that reuses one 33x33 signed
// multiplier (one product per step) and one restoring divider that produces
// one quotient bit per cycle. A zero temperature divisor or a zero B4 ends
// the item early with a fault result. One item is processed at a time, so
// the next item is taken only after the previous result has been taken.
// The result sits in the output with out_valid high until taken
// (out_stall low); the sequencer waits meanwhile.
// Reset (rst_n low, synchronous) clears the calibration registers to zero,
// oversampling to 3, both histories and the fill count. Configuration is
// written through cfg_wr_en / cfg_index / cfg_data; the user must write it
// only while idle, the block itself does not enforce this.
module baro_sensor_compensation_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bscf_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [bscf_pkg::CalWideW-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        in_raw_temperature,
  input  logic [23:0]                        in_raw_pressure,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 out_temperature_tenths,
  output logic signed [31:0]                 out_pressure_pa,
  output logic                               out_divide_fault,
  output logic                               out_settled
);
  import bscf_pkg::*;

  logic [47:0] ac123_r, ac456_r;
  logic [31:0] b12_r, mcmd_r;
  logic [1:0]  oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac123_r <= '0;
      ac456_r <= '0;
      b12_r   <= '0;
      mcmd_r  <= '0;
      oss_r   <= 2'd3;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_AC123: ac123_r <= cfg_data;
        REG_AC456: ac456_r <= cfg_data;
        REG_B12:   b12_r   <= cfg_data[31:0];
        REG_MCMD:  mcmd_r  <= cfg_data[31:0];
        REG_OSS:   oss_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0] ac4, ac5, ac6;
  assign ac1 = ac123_r[47:32];
  assign ac2 = ac123_r[31:16];
  assign ac3 = ac123_r[15:0];
  assign ac4 = ac456_r[47:32];
  assign ac5 = ac456_r[31:16];
  assign ac6 = ac456_r[15:0];
  assign b1  = b12_r[31:16];
  assign b2  = b12_r[15:0];
  assign mc  = mcmd_r[31:16];
  assign md  = mcmd_r[15:0];

  state_t st_r, st_nxt;

  logic [15:0] ut_r;
  logic [23:0] up_raw_r;
  logic signed [31:0] x1_r, x2_r, b6_r, sq_r, b3_r, p_r, acc_r;
  logic [31:0] b4_r, b7_r;
  logic signed [15:0] t_r;

  // shared multiplier, 33x33 signed, product registered
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [65:0] prod_r;
  assign prod = ma * mb;

  // serial divider (unsigned magnitude, 32 steps)
  logic [5:0]  dcnt_r;
  logic [31:0] dnum_r, dq_r, dden_r;
  logic [31:0] drem_r;
  logic        dneg_r;
  logic        div_go;
  logic [31:0] div_num, div_den;
  logic        div_neg;
  logic [32:0] drem_sh;
  assign drem_sh = {drem_r, dnum_r[31]};

  logic [1:0] fill_r;
  logic signed [31:0] ph_r [3];
  logic signed [15:0] th_r [3];

  // helpers
  logic signed [31:0] den_t;
  logic signed [31:0] pnew;
  logic signed [31:0] b3a;
  logic [31:0] upv;
  logic signed [31:0] psum, x3q, qv;
  logic signed [17:0] tsum;

  assign den_t = x1_r + 32'(md);
  assign upv   = {8'd0, up_raw_r} >> (4'd8 - {2'd0, oss_r});
  assign qv    = b7_r[31] ? {dq_r[29:0], 2'b00} : dq_r;

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      ST_X1_MUL: begin
        ma = 33'(signed'({1'b0, ut_r})) - 33'(signed'({1'b0, ac6}));
        mb = 33'(signed'({1'b0, ac5}));
      end
      ST_SQ_MUL:  begin ma = 33'(b6_r); mb = 33'(b6_r); end
      ST_X1P_MUL: begin ma = 33'(b2);   mb = 33'(32'(prod_r) >>> 12); end
      ST_X2P_MUL: begin ma = 33'(ac2);  mb = 33'(b6_r); end
      ST_X1Q_MUL: begin ma = 33'(ac3);  mb = 33'(b6_r); end
      ST_X2Q_MUL: begin ma = 33'(b1);   mb = 33'(sq_r); end
      ST_B4_MUL: begin
        ma = 33'(signed'({1'b0, ac4}));
        mb = signed'({1'b0, 32'(x3q + 32'(K_OFS))});
      end
      ST_B7_MUL: begin
        ma = signed'({1'b0, upv - 32'(b3_r)});
        mb = signed'({1'b0, K_PSC >> oss_r});
      end
      ST_P_SQ:  begin ma = 33'(qv >>> 8); mb = 33'(qv >>> 8); end
      ST_P_C1:  begin ma = 33'(32'(prod_r)); mb = 33'(K_C1); end
      ST_P_C2:  begin ma = 33'(K_C2); mb = 33'(p_r); end
      default: ;
    endcase
  end

  // second pressure term comes straight off the registered product
  assign x3q = (32'(x1_r + (32'(prod_r) >>> 16) + 32'sd2)) >>> 2;

  // B4 zero test straight off the registered product
  logic b4_zero;
  assign b4_zero = (prod_r[31:15] == 17'd0);

  // next-state logic
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:    if (in_valid) st_nxt = ST_X1_MUL;
      ST_X1_MUL:  st_nxt = ST_X1_DONE;
      ST_X1_DONE: st_nxt = ST_X2_DIV;
      ST_X2_DIV: begin
        if (dcnt_r == 6'd0 && den_t == 32'sd0) st_nxt = ST_OUT;
        else if (dcnt_r == 6'd33) st_nxt = ST_B5;
      end
      ST_B5:      st_nxt = ST_SQ_MUL;
      ST_SQ_MUL:  st_nxt = ST_X1P_MUL;
      ST_X1P_MUL: st_nxt = ST_X2P_MUL;
      ST_X2P_MUL: st_nxt = ST_B3;
      ST_B3:      st_nxt = ST_X1Q_MUL;
      ST_X1Q_MUL: st_nxt = ST_X2Q_MUL;
      ST_X2Q_MUL: st_nxt = ST_B4_MUL;
      ST_B4_MUL:  st_nxt = ST_B4_CHK;
      ST_B4_CHK:  st_nxt = b4_zero ? ST_OUT : ST_B7_MUL;
      ST_B7_MUL:  st_nxt = ST_Q_DIV;
      ST_Q_DIV:   if (dcnt_r == 6'd33) st_nxt = ST_P_SQ;
      ST_P_SQ:    st_nxt = ST_P_C1;
      ST_P_C1:    st_nxt = ST_P_C2;
      ST_P_C2:    st_nxt = ST_P_FIN;
      ST_P_FIN:   st_nxt = ST_OUT;
      ST_OUT:     if (!out_stall) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // output logic
  always_comb begin
    in_stall  = (st_r != ST_IDLE);
    out_valid = (st_r == ST_OUT);
  end

  // divider operand selection (first cycle of a divide)
  always_comb begin
    div_go  = 1'b0;
    div_num = '0;
    div_den = '1;
    div_neg = 1'b0;
    if (st_r == ST_X2_DIV && dcnt_r == 6'd0 && den_t != 32'sd0) begin
      div_go  = 1'b1;
      div_num = (mc < 0) ? 32'(-(32'(mc) <<< 11)) : 32'(32'(mc) <<< 11);
      div_den = den_t[31] ? 32'(-den_t) : den_t;
      div_neg = mc[15] ^ den_t[31];
    end else if (st_r == ST_Q_DIV && dcnt_r == 6'd0) begin
      div_go  = 1'b1;
      div_num = prod_r[31] ? 32'(prod_r) : {prod_r[30:0], 1'b0};
      div_den = b4_r;
    end
  end

  assign b3a  = ((32'(ac1) <<< 2) + x1_r + x2_r) <<< oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      dcnt_r <= '0;
      fill_r <= '0;
      for (int i = 0; i < 3; i++) begin
        ph_r[i] <= '0;
        th_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (div_go) dcnt_r <= 6'd1;
      else if (dcnt_r != 6'd0 && dcnt_r != 6'd33) dcnt_r <= dcnt_r + 6'd1;
      else dcnt_r <= '0;
      if (st_r == ST_P_FIN) begin
        ph_r[2] <= ph_r[1];
        ph_r[1] <= ph_r[0];
        ph_r[0] <= pnew;
        th_r[2] <= th_r[1];
        th_r[1] <= th_r[0];
        th_r[0] <= t_r;
        if (fill_r != 2'd3) fill_r <= fill_r + 2'd1;
      end
    end
  end

  assign pnew = p_r + ((32'(x1_r + (32'(prod_r) >>> 16) + K_C3)) >>> 4);

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (div_go) begin
      dnum_r <= div_num;
      dden_r <= div_den;
      drem_r <= '0;
      dq_r   <= '0;
      dneg_r <= div_neg;
    end else if (dcnt_r != 6'd0 && dcnt_r != 6'd33) begin
      dnum_r <= {dnum_r[30:0], 1'b0};
      if (drem_sh >= {1'b0, dden_r}) begin
        drem_r <= 32'(drem_sh - {1'b0, dden_r});
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= drem_sh[31:0];
        dq_r   <= {dq_r[30:0], 1'b0};
      end
    end
    case (st_r)
      ST_IDLE: begin
        ut_r     <= in_raw_temperature;
        up_raw_r <= in_raw_pressure;
      end
      ST_X1_DONE: x1_r <= 32'(prod_r >>> 15);
      ST_B5: begin
        x2_r <= dneg_r ? -dq_r : dq_r;
        b6_r <= x1_r + (dneg_r ? -dq_r : dq_r) - K_T0;
        acc_r <= x1_r + (dneg_r ? -dq_r : dq_r) + 32'sd8;
      end
      ST_SQ_MUL: begin
        t_r <= (acc_r >>> 4) > 32'sd32767 ? 16'sd32767 :
               (acc_r >>> 4) < -32'sd32768 ? -16'sd32768 : 16'(acc_r >>> 4);
      end
      ST_X1P_MUL: sq_r <= 32'(prod_r) >>> 12;
      ST_X2P_MUL: x1_r <= 32'(prod_r) >>> 11;
      ST_B3:      x2_r <= 32'(prod_r) >>> 11;
      ST_X1Q_MUL: b3_r <= (32'(b3a + 32'sd2)) >>> 2;
      ST_X2Q_MUL: x1_r <= 32'(prod_r) >>> 13;
      ST_B4_MUL:  x2_r <= 32'(prod_r) >>> 16;
      ST_B4_CHK:  b4_r <= 32'(prod_r) >> 15;
      ST_Q_DIV:   if (dcnt_r == 6'd0) b7_r <= 32'(prod_r);
      ST_P_SQ:    p_r  <= qv;
      ST_P_C1:    x1_r <= 32'(prod_r);
      ST_P_C2:    x1_r <= 32'(prod_r) >>> 16;
      ST_P_FIN:   x2_r <= 32'(prod_r) >>> 16;
      default: ;
    endcase
  end

  logic fault_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_X1_DONE) fault_r <= 1'b0;
    if (st_r == ST_X2_DIV && dcnt_r == 6'd0 && den_t == 32'sd0) fault_r <= 1'b1;
    if (st_r == ST_B4_CHK && b4_zero) fault_r <= 1'b1;
  end

  assign psum = ph_r[2] + ph_r[1] + (ph_r[0] <<< 1);
  assign tsum = 18'(th_r[2]) + 18'(th_r[1]) + (18'(th_r[0]) <<< 1);

  always_comb begin
    out_divide_fault = fault_r;
    out_settled      = (fill_r == 2'd3);
    if (fault_r) begin
      out_temperature_tenths = '0;
      out_pressure_pa        = '0;
    end else begin
      out_temperature_tenths = 16'((tsum + (tsum[17] ? 18'sd3 : 18'sd0)) >>> 2);
      out_pressure_pa = (psum + (psum[31] ? 32'sd3 : 32'sd0)) >>> 2;
    end
  end

endmodule

// ===== design/bscf_checker.sv =====
// Port-level checker for the compensation filter, bound to the top level
module bscf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_divide_fault,
  input logic signed [31:0] out_pressure_pa,
  input logic signed [15:0] out_temperature_tenths
);
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pressure_pa))
    else $error("stalled result changed");
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_pressure_pa == 0 &&
    out_temperature_tenths == 0) else $error("fault result not zero");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule

bind baro_sensor_compensation_filter bscf_checker u_bscf_checker (.*);

// ===== tb/sv/baro_sensor_compensation_filter_checker.sv =====
// Checker for the pressure compensation filter: mirrors config, predicts and compares
`timescale 1ns / 1ps

module baro_sensor_compensation_filter_checker
  import bscf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CalWideW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [15:0]         in_raw_temperature,
  input  logic [23:0]         in_raw_pressure,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic signed [15:0]  out_temperature_tenths,
  input  logic signed [31:0]  out_pressure_pa,
  input  logic                out_divide_fault,
  input  logic                out_settled,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);

  typedef struct {
    logic signed [15:0] temp;
    logic signed [31:0] pres;
    logic               fault;
    logic               settled;
  } reading_t;

  reading_t readings_due[$];

  logic [47:0] ac123, ac456;
  logic [31:0] b12, mcmd;
  logic [1:0]  oss;
  longint      pres_hist[3];
  longint      temp_hist[3];
  int          fill;

  function automatic longint wrap32(longint x);
    logic signed [31:0] v;
    v = x[31:0];
    return v;
  endfunction

  function automatic longint sext16(logic [15:0] v);
    logic signed [15:0] s;
    s = v;
    return s;
  endfunction

  function automatic reading_t compensate(logic [15:0] raw_t, logic [23:0] raw_p);
    reading_t r;
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    longint ut, up, x1, x2, x3, b5, b6, sq, b3, den, t, pres, p, ps, ts;
    logic [63:0] ac4, b4, b7, q;
    ac1 = sext16(ac123[47:32]);
    ac2 = sext16(ac123[31:16]);
    ac3 = sext16(ac123[15:0]);
    ac4 = ac456[47:32];
    ac5 = longint'(ac456[31:16]);
    ac6 = longint'(ac456[15:0]);
    b1  = sext16(b12[31:16]);
    b2  = sext16(b12[15:0]);
    mc  = sext16(mcmd[31:16]);
    md  = sext16(mcmd[15:0]);
    ut  = longint'(raw_t);
    up  = longint'(raw_p >> (8 - oss));
    r.fault   = 1'b1;
    r.temp    = '0;
    r.pres    = '0;
    r.settled = (fill >= 3);

    x1  = ((ut - ac6) * ac5) >>> 15;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t  = (b5 + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;

    b6 = wrap32(b5 - 4000);
    sq = wrap32(b6 * b6) >>> 12;
    x1 = wrap32(b2 * sq) >>> 11;
    x2 = wrap32(ac2 * b6) >>> 11;
    x3 = wrap32(x1 + x2);
    b3 = wrap32(ac1 * 4 + x3);
    b3 = wrap32(b3 * (longint'(1) << oss));
    b3 = wrap32(b3 + 2) >>> 2;
    x1 = wrap32(ac3 * b6) >>> 13;
    x2 = wrap32(b1 * sq) >>> 16;
    x3 = wrap32(x1 + x2 + 2) >>> 2;
    b4 = ((ac4 * (64'(x3 + 32768) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) >> 15;
    if (b4 == 0) return r;
    b7 = ((64'(up - b3) & 64'hFFFF_FFFF) * 64'(50000 >> oss)) & 64'hFFFF_FFFF;
    if (b7 < 64'h8000_0000) q = (b7 << 1) / b4;
    else q = ((b7 / b4) << 2) & 64'hFFFF_FFFF;
    p    = wrap32(longint'(q));
    x1   = p >>> 8;
    x1   = wrap32(x1 * x1);
    x1   = wrap32(x1 * 3038) >>> 16;
    x2   = wrap32(-7357 * p) >>> 16;
    pres = wrap32(p + (wrap32(x1 + x2 + 3791) >>> 4));

    pres_hist[2] = pres_hist[1];
    pres_hist[1] = pres_hist[0];
    pres_hist[0] = pres;
    temp_hist[2] = temp_hist[1];
    temp_hist[1] = temp_hist[0];
    temp_hist[0] = t;
    if (fill < 3) fill++;

    ps = wrap32(pres_hist[2] + pres_hist[1] + 2 * pres_hist[0]);
    ts = temp_hist[2] + temp_hist[1] + 2 * temp_hist[0];
    r.temp    = 16'(ts / 4);
    r.pres    = 32'(ps / 4);
    r.fault   = 1'b0;
    r.settled = (fill >= 3);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      ac123 <= '0; ac456 <= '0; b12 <= '0; mcmd <= '0; oss <= 2'd3;
      for (int i = 0; i < 3; i++) begin
        pres_hist[i] = 0;
        temp_hist[i] = 0;
      end
      fill = 0;
      readings_due.delete();
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_AC123: ac123 <= cfg_data;
          REG_AC456: ac456 <= cfg_data;
          REG_B12:   b12   <= cfg_data[31:0];
          REG_MCMD:  mcmd  <= cfg_data[31:0];
          REG_OSS:   oss   <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        readings_due.push_back(compensate(in_raw_temperature, in_raw_pressure));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (readings_due.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = readings_due.pop_front();
          if (out_temperature_tenths !== want.temp ||
              out_pressure_pa !== want.pres ||
              out_divide_fault !== want.fault ||
              out_settled !== want.settled)
            fail_count <= fail_count + 1;
          if (out_temperature_tenths !== want.temp)
            $error("temperature_tenths: expected %0d, got %0d",
                   want.temp, out_temperature_tenths);
          if (out_pressure_pa !== want.pres)
            $error("pressure_pa: expected %0d, got %0d", want.pres, out_pressure_pa);
          if (out_divide_fault !== want.fault)
            $error("divide_fault: expected %0b, got %0b", want.fault, out_divide_fault);
          if (out_settled !== want.settled)
            $error("settled: expected %0b, got %0b", want.settled, out_settled);
        end
      end
    end
  end

  assign pending = readings_due.size();

endmodule

// ===== tb/sv/baro_sensor_compensation_filter_tb.sv =====
// Testbench top: clock, reset, calibration phases, item stimulus and verdict
`timescale 1ns / 1ps

module baro_sensor_compensation_filter_tb;
  import bscf_pkg::*;

  localparam logic [CfgIdxW-1:0] UNUSED_REG = 3'd7;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_WAIT = 120;

  logic                clk, rst_n;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CalWideW-1:0] cfg_data;
  logic                in_valid, in_stall;
  logic [15:0]         in_raw_temperature;
  logic [23:0]         in_raw_pressure;
  logic                out_valid, out_stall;
  logic signed [15:0]  out_temperature_tenths;
  logic signed [31:0]  out_pressure_pa;
  logic                out_divide_fault, out_settled;
  int                  fail_count, pending, results_seen;
  int                  items_sent, cycles;
  logic                hold_req, calm;

  baro_sensor_compensation_filter dut (.*);

  baro_sensor_compensation_filter_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request, calm stretches
  initial begin
    int r;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req <= 1'b0;
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r >= 60);
        if (r < 60) repeat ($urandom_range(0, 7)) @(posedge clk);
        else if (r < 95) repeat ($urandom_range(0, 3)) @(posedge clk);
        else repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic send_reading(logic [15:0] raw_t, logic [23:0] raw_p);
    int g, r;
    in_valid           <= 1'b1;
    in_raw_temperature <= raw_t;
    in_raw_pressure    <= raw_p;
    do @(posedge clk); while (in_stall);
    items_sent++;
    r = $urandom_range(0, 99);
    if (calm || r < 50) g = 0;
    else if (r < 92) g = $urandom_range(1, 4);
    else g = $urandom_range(20, 150);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one edge first so the checker has queued the last item
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic load_calibration(logic [47:0] a123, logic [47:0] a456,
                                  logic [31:0] bb, logic [31:0] mm, logic [1:0] os);
    logic [47:0] vals[5];
    cfg_reg_t    regs[5];
    regs = '{REG_AC123, REG_AC456, REG_B12, REG_MCMD, REG_OSS};
    vals = '{a123, a456, 48'(bb), 48'(mm), 48'(os)};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    // an unmapped index must be ignored
    cfg_index <= UNUSED_REG;
    cfg_data  <= 48'({$urandom, $urandom});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // typical factory calibration, optionally jittered
  task automatic load_typical(logic [1:0] os, bit jitter);
    logic [15:0] c[11];
    c = '{16'(408), 16'(-72), 16'(-14383), 16'(32741), 16'(32757), 16'(23153),
          16'(6190), 16'(4), 16'(-8711), 16'(2868), 16'(0)};
    if (jitter)
      for (int i = 0; i < 10; i++) c[i] = c[i] + 16'($urandom_range(0, 64)) - 16'd32;
    load_calibration({c[0], c[1], c[2]}, {c[3], c[4], c[5]}, {c[6], c[7]},
                     {c[8], c[9]}, os);
  endtask

  task automatic random_readings(int n, bit realistic_cal);
    int r;
    logic [15:0] ut;
    logic [23:0] up;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (realistic_cal && r < 75) begin
        ut = 16'($urandom_range(20000, 36000));
        up = 24'($urandom_range(5_000_000, 12_000_000));
      end else begin
        ut = 16'($urandom);
        up = 24'($urandom);
      end
      send_reading(ut, up);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    items_sent = 0;
    hold_req = 1'b0;
    calm = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_AC123;
    cfg_data = '0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: every item hits the zero-divisor path
    send_reading(16'h0000, 24'h000000);
    send_reading(16'hFFFF, 24'hFFFFFF);
    wait_idle();

    // directed: typical calibration, extremes, history fill and settle
    load_typical(2'd0, 1'b0);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'h0000, 24'h000000);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'h0000, 24'hFFFFFF);
    send_reading(16'hFFFF, 24'h000000);
    wait_idle();
    // B4 zero with a full history: fault while settled
    load_calibration({16'(408), 16'(-72), 16'(-14383)}, 48'h0000_7FF5_5A71,
                     32'h182E_0004, 32'hDDF9_0B34, 2'd3);
    send_reading(16'd27898, 24'h5D2300);
    wait_idle();
    // temperature divisor zero: MD is zero and X1 = 0 when UT = AC6
    load_calibration(48'h0198_FFB8_C7D1, 48'h7FE5_7FF5_5A71, 32'h182E_0004,
                     32'hDDF9_0000, 2'd1);
    send_reading(16'h5A71, 24'h800000);
    send_reading(16'd27898, 24'h800000);
    wait_idle();
    // all-ones calibration
    load_calibration('1, '1, '1, '1, 2'd3);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'h0000, 24'h000001);
    wait_idle();

    // receiver holds off long while items keep coming
    load_typical(2'd2, 1'b0);
    hold_req <= 1'b1;
    random_readings(8, 1'b1);
    wait_idle();

    // random phases across oversampling and calibration styles
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 3);
      case (ph % 5)
        0, 1: load_typical(2'(ph), 1'(ph % 2));
        2: load_typical(2'($urandom), 1'b1);
        3: load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                            $urandom, $urandom, 2'($urandom));
        default: load_typical(2'd3, 1'b1);
      endcase
      random_readings(100, (ph % 5) != 3);
      wait_idle();
    end

    $display("%0d items sent, %0d results checked over calibration, oversampling",
             items_sent, results_seen);
    $display("and stall phases, including divide faults and history settling");
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
